// ===== sv/best_fit_heap_allocator_top_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bfha_pkg.sv =====
// Types, constants and helpers of the best-fit heap allocator.
package bfha_pkg;
	localparam int HEAP_MAX  = 16384;
	localparam int FREE_MAX  = 512;
	localparam int HEAP_MIN  = 4096;
	localparam int SPLIT_MIN = 32;
	localparam int HDR_BYTES = 8;
	localparam int WORDS     = HEAP_MAX / 4;
	localparam int WA_W      = $clog2(WORDS);
	localparam int FA_W      = $clog2(FREE_MAX);
	localparam int CNT_W     = $clog2(FREE_MAX + 1);
	localparam int SZ_W      = 15;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BADSIZE = 2'd1;
	localparam logic [1:0] STAT_NOFIT   = 2'd2;
	localparam logic [1:0] STAT_BADFREE = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [13:0] request_bytes;
		logic [13:0] free_offset;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] payload_offset;
		logic [14:0] chunk_bytes;
	} result_t;

	typedef struct packed {
		logic            is_free;
		logic [SZ_W-1:0] size;
	} hdr_t;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_CHK,
		ST_A_SCAN, ST_A_PICK, ST_A_SPLIT,
		ST_RM_RD, ST_RM_WR,
		ST_F_RD, ST_F_WAIT, ST_F_NXT, ST_F_DEC,
		ST_FIND_RD, ST_FIND_WAIT,
		ST_INS_RD, ST_INS_WAIT,
		ST_DONE
	} state_t;

	// Heap size register: raised to the minimum, rounded up to a word, saturated.
	function automatic logic [SZ_W-1:0] heap_clamp(input logic [SZ_W-1:0] v);
		logic [SZ_W:0] r;
		r = ({1'b0, v} + (SZ_W+1)'(3)) & ~(SZ_W+1)'(3);
		if (v < SZ_W'(HEAP_MIN))
			r = (SZ_W+1)'(HEAP_MIN);
		else if (r > (SZ_W+1)'(HEAP_MAX))
			r = (SZ_W+1)'(HEAP_MAX);
		return r[SZ_W-1:0];
	endfunction
endpackage

// ===== sv/bfha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/best_fit_heap_allocator_top.sv =====
// Best-fit heap allocator: header store, sorted free list and control sequencer.
// A rejected allocate goes straight to done; an allocate scans the whole free list for the
// best fit and shifts later list entries down when the whole chunk is taken; a free walks
// the chunks up to its own, then searches or shifts free-list entries.
// One item is in flight at a time; the next is accepted in the idle cycle after done.
// After reset or a heap size write, the INIT state rebuilds the single free chunk.
module best_fit_heap_allocator_top import bfha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);
`include "best_fit_heap_allocator_top_defines.svh"

	state_t state_q, state_d;

	logic [SZ_W-1:0]  heap_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cmd_q;
	result_t          res_q;

	logic [15:0]      need_q;
	logic [CNT_W-1:0] scan_i_q;
	logic             v1_q, v2_q;
	logic [FA_W-1:0]  i1_q, i2_q;
	logic             found_q;
	logic [FA_W-1:0]  best_q;
	logic [SZ_W-1:0]  bsize_q;
	logic [WA_W-1:0]  boff_q;

	logic [CNT_W-1:0] k_q;
	logic [SZ_W-1:0]  cur_q, nxt_q, size_q, prev_size_q;
	logic [13:0]      prev_q;
	logic             pf_q, has_prev_q, rm_mode_q;
	logic [WA_W-1:0]  target_q;

	logic            h_we, f_we;
	logic [WA_W-1:0] h_waddr, h_raddr;
	hdr_t            h_wdata, hd;
	logic [FA_W-1:0] f_waddr, f_raddr;
	logic [WA_W-1:0] f_wdata, f_rdata;

	bfha_ram #(.WIDTH($bits(hdr_t)), .DEPTH(WORDS)) u_hdr_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(hd)
	);

	bfha_ram #(.WIDTH(WA_W), .DEPTH(FREE_MAX)) u_list_ram (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	logic            cfg_wr, accept;
	logic [15:0]     req_round;
	logic            split, scan_end, issue, hit, nf, pf, find_end, match;
	logic [FA_W-1:0] find_idx;
	logic [SZ_W-1:0] sum_pn, sum_p, sum_n;
	logic [WA_W-1:0] cur_w;

	// A pending item takes precedence over a configuration write.
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign busy      = (state_q != ST_IDLE);
	assign done      = (state_q == ST_DONE);
	assign result    = res_q;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign accept    = start && !busy;

	assign req_round = ({2'b0, cmd_q.request_bytes} + 16'd3) & 16'hFFFC;
	assign split     = {1'b0, bsize_q} >= need_q + 16'(SPLIT_MIN);
	assign issue     = scan_i_q < count_q;
	assign scan_end  = !issue && !v1_q && !v2_q;
	assign hit       = (cur_q + SZ_W'(HDR_BYTES)) == {1'b0, cmd_q.free_offset};
	assign nf        = (nxt_q < heap_q) && hd.is_free;
	assign pf        = has_prev_q && pf_q;
	assign sum_p     = prev_size_q + size_q;
	assign sum_pn    = sum_p + hd.size;
	assign sum_n     = size_q + hd.size;
	assign cur_w     = cur_q[WA_W+1:2];
	assign match     = (f_rdata == target_q);
	assign find_end  = match || (k_q + CNT_W'(1) >= count_q);
	assign find_idx  = match ? k_q[FA_W-1:0] : '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: state_d = ST_IDLE;
			ST_IDLE: begin
				if (cfg_wr)
					state_d = ST_INIT;
				else if (accept)
					state_d = ST_CHK;
			end
			ST_CHK: begin
				if (cmd_q.operation)
					state_d = ST_F_RD;
				else if (cmd_q.request_bytes == '0 || {1'b0, cmd_q.request_bytes} > heap_q
						|| count_q == '0)
					state_d = ST_DONE;
				else
					state_d = ST_A_SCAN;
			end
			ST_A_SCAN: if (scan_end) state_d = ST_A_PICK;
			ST_A_PICK: begin
				if (!found_q)
					state_d = ST_DONE;
				else if (split)
					state_d = ST_A_SPLIT;
				else
					state_d = ST_RM_RD;
			end
			ST_A_SPLIT: state_d = ST_DONE;
			ST_RM_RD: state_d = (k_q + CNT_W'(1) < count_q) ? ST_RM_WR : ST_DONE;
			ST_RM_WR: state_d = ST_RM_RD;
			ST_F_RD: state_d = (cur_q >= heap_q) ? ST_DONE : ST_F_WAIT;
			ST_F_WAIT: begin
				if (hit)
					state_d = hd.is_free ? ST_DONE : ST_F_NXT;
				else if (hd.size == '0)
					state_d = ST_DONE;
				else
					state_d = ST_F_RD;
			end
			ST_F_NXT: state_d = ST_F_DEC;
			ST_F_DEC: begin
				priority if (!pf && !nf && count_q >= CNT_W'(FREE_MAX))
					state_d = ST_DONE;
				else if (nf)
					state_d = ST_FIND_RD;
				else if (pf)
					state_d = ST_DONE;
				else
					state_d = ST_INS_RD;
			end
			ST_FIND_RD: state_d = ST_FIND_WAIT;
			ST_FIND_WAIT: begin
				if (!find_end)
					state_d = ST_FIND_RD;
				else
					state_d = rm_mode_q ? ST_RM_RD : ST_DONE;
			end
			ST_INS_RD: state_d = (k_q != '0) ? ST_INS_WAIT : ST_DONE;
			ST_INS_WAIT: state_d = (f_rdata > cur_w) ? ST_INS_RD : ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = '0;
		h_raddr = '0;
		f_we    = 1'b0;
		f_waddr = '0;
		f_wdata = '0;
		f_raddr = '0;
		unique case (state_q)
			ST_INIT: begin
				h_we    = 1'b1;
				h_wdata = '{is_free: 1'b1, size: heap_q};
				f_we    = 1'b1;
			end
			ST_A_SCAN: begin
				f_raddr = scan_i_q[FA_W-1:0];
				h_raddr = f_rdata;
			end
			ST_A_PICK: begin
				if (found_q) begin
					h_we    = 1'b1;
					h_waddr = boff_q;
					h_wdata = '{is_free: 1'b0, size: split ? need_q[SZ_W-1:0] : bsize_q};
					if (split) begin
						f_we    = 1'b1;
						f_waddr = best_q;
						f_wdata = boff_q + need_q[WA_W+1:2];
					end
				end
			end
			ST_A_SPLIT: begin
				h_we    = 1'b1;
				h_waddr = boff_q + need_q[WA_W+1:2];
				h_wdata = '{is_free: 1'b1, size: bsize_q - need_q[SZ_W-1:0]};
			end
			ST_RM_RD: f_raddr = FA_W'(k_q + CNT_W'(1));
			ST_RM_WR: begin
				f_we    = 1'b1;
				f_waddr = k_q[FA_W-1:0];
				f_wdata = f_rdata;
			end
			ST_F_RD: h_raddr = cur_w;
			ST_F_NXT: h_raddr = nxt_q[WA_W+1:2];
			ST_F_DEC: begin
				if (pf || nf || count_q < CNT_W'(FREE_MAX)) begin
					h_we = 1'b1;
					if (pf) begin
						h_waddr = prev_q[WA_W+1:2];
						h_wdata = '{is_free: 1'b1, size: nf ? sum_pn : sum_p};
					end else begin
						h_waddr = cur_w;
						h_wdata = '{is_free: 1'b1, size: nf ? sum_n : size_q};
					end
				end
			end
			ST_FIND_RD: f_raddr = k_q[FA_W-1:0];
			ST_FIND_WAIT: begin
				if (find_end && !rm_mode_q) begin
					f_we    = 1'b1;
					f_waddr = find_idx;
					f_wdata = cur_w;
				end
			end
			ST_INS_RD: begin
				f_raddr = FA_W'(k_q - CNT_W'(1));
				if (k_q == '0) begin
					f_we    = 1'b1;
					f_waddr = '0;
					f_wdata = cur_w;
				end
			end
			ST_INS_WAIT: begin
				f_we    = 1'b1;
				f_waddr = k_q[FA_W-1:0];
				f_wdata = (f_rdata > cur_w) ? f_rdata : cur_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			heap_q  <= SZ_W'(HEAP_MIN);
			count_q <= CNT_W'(1);
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_INIT: count_q <= CNT_W'(1);
				ST_IDLE: begin
					if (cfg_wr)
						heap_q <= heap_clamp(cfg_data);
				end
				ST_A_SCAN: begin
					v1_q <= issue;
					v2_q <= v1_q;
				end
				ST_RM_RD: begin
					if (!(k_q + CNT_W'(1) < count_q))
						count_q <= count_q - CNT_W'(1);
				end
				ST_INS_RD: if (k_q == '0) count_q <= count_q + CNT_W'(1);
				ST_INS_WAIT: if (!(f_rdata > cur_w)) count_q <= count_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) cmd_q <= cmd;
			ST_CHK: begin
				res_q      <= '{status: STAT_OK, payload_offset: '0, chunk_bytes: '0};
				need_q     <= req_round + 16'(HDR_BYTES);
				scan_i_q   <= '0;
				found_q    <= 1'b0;
				bsize_q    <= '0;
				cur_q      <= '0;
				has_prev_q <= 1'b0;
				pf_q       <= 1'b0;
				if (!cmd_q.operation) begin
					if (cmd_q.request_bytes == '0 || {1'b0, cmd_q.request_bytes} > heap_q)
						res_q.status <= STAT_BADSIZE;
					else if (count_q == '0)
						res_q.status <= STAT_NOFIT;
				end
			end
			ST_A_SCAN: begin
				if (issue) begin
					scan_i_q <= scan_i_q + CNT_W'(1);
					i1_q     <= scan_i_q[FA_W-1:0];
				end
				i2_q <= i1_q;
				if (v2_q && {1'b0, hd.size} >= need_q && (!found_q || hd.size <= bsize_q)) begin
					found_q <= 1'b1;
					bsize_q <= hd.size;
					best_q  <= i2_q;
				end
				target_q <= h_raddr;
				if (v2_q && {1'b0, hd.size} >= need_q && (!found_q || hd.size <= bsize_q))
					boff_q <= target_q;
			end
			ST_A_PICK: begin
				k_q <= CNT_W'(best_q);
				if (!found_q)
					res_q.status <= STAT_NOFIT;
				else begin
					res_q.payload_offset <= {boff_q, 2'b00} + 14'(HDR_BYTES);
					res_q.chunk_bytes    <= split ? need_q[SZ_W-1:0] : bsize_q;
				end
			end
			ST_RM_WR: k_q <= k_q + CNT_W'(1);
			ST_F_RD: if (cur_q >= heap_q) res_q.status <= STAT_BADFREE;
			ST_F_WAIT: begin
				if (hit) begin
					size_q <= hd.size;
					nxt_q  <= cur_q + hd.size;
					if (hd.is_free)
						res_q.status <= STAT_BADFREE;
				end else if (hd.size == '0) begin
					res_q.status <= STAT_BADFREE;
				end else begin
					prev_q      <= cur_q[13:0];
					prev_size_q <= hd.size;
					pf_q        <= hd.is_free;
					has_prev_q  <= 1'b1;
					cur_q       <= cur_q + hd.size;
				end
			end
			ST_F_DEC: begin
				k_q       <= nf ? '0 : count_q;
				target_q  <= nxt_q[WA_W+1:2];
				rm_mode_q <= pf;
				priority if (!pf && !nf && count_q >= CNT_W'(FREE_MAX))
					res_q.status <= STAT_BADFREE;
				else if (pf) begin
					res_q.payload_offset <= prev_q + 14'(HDR_BYTES);
					res_q.chunk_bytes    <= nf ? sum_pn : sum_p;
				end else begin
					res_q.payload_offset <= cur_q[13:0] + 14'(HDR_BYTES);
					res_q.chunk_bytes    <= nf ? sum_n : size_q;
				end
			end
			ST_FIND_WAIT: begin
				if (!find_end)
					k_q <= k_q + CNT_W'(1);
				else
					k_q <= CNT_W'(find_idx);
			end
			ST_INS_WAIT: if (f_rdata > cur_w) k_q <= k_q - CNT_W'(1);
			default: ;
		endcase
	end

	`BFHA_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(FREE_MAX), "free count overflow")
	`BFHA_ASSERT_IMP(a_err_zero, done && res_q.status != STAT_OK,
		res_q.payload_offset == '0 && res_q.chunk_bytes == '0, "error result not zero")
	`BFHA_ASSERT_NXT(a_accept_busy, start && !busy && !cfg_wr, busy, "accepted item not busy")
	`BFHA_ASSERT_NXT(a_cfg_init, cfg_wr, state_q == ST_INIT, "config write did not reinit")
	`BFHA_ASSERT_NXT(a_done_idle, done, !busy, "busy after result")
endmodule
